// ===== hdl/pfa_pkg.sv =====
// pfa_pkg: shared constants, command codes and structs of the page frame allocator
// no dependencies
`timescale 1ns / 1ps

package pfa_pkg;

	localparam int FRAMES = 32;
	localparam int IDX_W  = $clog2(FRAMES);
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int PID_W  = 5;
	localparam int SEG_W  = 2;
	localparam int PAGE_W = 8;
	localparam int BASE_W = 8;
	localparam int MARK_W = 6;
	localparam int FRAME_W = 9;

	localparam logic [0:0] CMD_ALLOC   = 1'b0;
	localparam logic [0:0] CMD_RELEASE = 1'b1;

	localparam logic [SEG_W-1:0] SHARED_SEG = 2'd2;

	localparam logic [0:0] REG_FRAME_BASE = 1'b0;
	localparam logic [0:0] REG_LOW_MARK   = 1'b1;

	typedef logic [FRAMES-1:0] frame_vec_t;

	// table update for one transaction
	typedef struct packed {
		logic              claim;
		logic [IDX_W-1:0]  claim_idx;
		logic [PID_W-1:0]  pid;
		logic [SEG_W-1:0]  seg;
		logic [PAGE_W-1:0] page;
		logic              release_en;
		frame_vec_t        rel_vec;
	} table_upd_t;

	// match vectors from the table
	typedef struct packed {
		frame_vec_t free_vec;
		frame_vec_t share_vec;
		frame_vec_t rel_vec;
	} table_match_t;

	// priority picks and counts
	typedef struct packed {
		logic             free_any;
		logic [IDX_W-1:0] free_idx;
		logic             share_any;
		logic [IDX_W-1:0] share_idx;
		logic [CNT_W-1:0] rel_cnt;
	} pick_t;

endpackage

// ===== hdl/page_frame_allocator_shared.sv =====
// page_frame_allocator_shared: an accepted start passes the input register (valid_s1), then done is registered from it;
// one transaction accepted every cycle, busy stays low.
// the table lookup, pick and update fit between the input and result registers.
// reset clears all used bits, free count to 32, frame_base to 0, low_mark to 2;
// no clearing pass, the block takes work in the first cycle after reset.
// depends on pfa_pkg, pfa_table, pfa_pick
`timescale 1ns / 1ps

module page_frame_allocator_shared import pfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [PID_W-1:0]   process_id,
	input  logic [SEG_W-1:0]   segment,
	input  logic [PAGE_W-1:0]  page,
	output logic               done,
	output logic [FRAME_W-1:0] frame,
	output logic               granted,
	output logic               shared_hit,
	output logic               wake_evictor,
	output logic [CNT_W-1:0]   freed,
	input  logic               wr_en,
	input  logic [0:0]         wr_index,
	input  logic [BASE_W-1:0]  wr_data
);

	logic [BASE_W-1:0] frame_base_q;
	logic [MARK_W-1:0] low_mark_q;
	logic [CNT_W-1:0]  free_count_q;

	logic              valid_s1;
	logic              cmd_s1;
	logic [PID_W-1:0]  pid_s1;
	logic [SEG_W-1:0]  seg_s1;
	logic [PAGE_W-1:0] page_s1;

	table_upd_t   upd;
	table_match_t match;
	pick_t        pick;

	logic             is_alloc;
	logic             hit;
	logic             claim;
	logic             is_rel;
	logic [CNT_W-1:0] free_next;
	logic [IDX_W-1:0] grant_idx;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
			low_mark_q   <= MARK_W'(2);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_BASE: frame_base_q <= wr_data;
				REG_LOW_MARK:   low_mark_q   <= wr_data[MARK_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1  <= command;
			pid_s1  <= process_id;
			seg_s1  <= segment;
			page_s1 <= page;
		end
	end

	pfa_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_pid  (pid_s1),
		.lookup_page (page_s1),
		.upd         (upd),
		.match       (match)
	);

	pfa_pick u_pick (
		.match (match),
		.pick  (pick)
	);

	always_comb begin
		is_alloc  = valid_s1 && (cmd_s1 == CMD_ALLOC);
		is_rel    = valid_s1 && (cmd_s1 == CMD_RELEASE);
		hit       = is_alloc && (seg_s1 == SHARED_SEG) && pick.share_any;
		claim     = is_alloc && !hit && pick.free_any;
		grant_idx = hit ? pick.share_idx : pick.free_idx;
		free_next = CNT_W'({1'b0, free_count_q}
			+ (is_rel ? {1'b0, pick.rel_cnt} : '0)
			- {{CNT_W{1'b0}}, claim});

		upd.claim      = claim;
		upd.claim_idx  = pick.free_idx;
		upd.pid        = pid_s1;
		upd.seg        = seg_s1;
		upd.page       = page_s1;
		upd.release_en = is_rel;
		upd.rel_vec    = match.rel_vec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= CNT_W'(FRAMES);
			done         <= 1'b0;
		end else begin
			done <= valid_s1;
			if (valid_s1) begin
				free_count_q <= free_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			granted      <= hit || claim;
			shared_hit   <= hit;
			frame        <= (hit || claim)
				? FRAME_W'({1'b0, frame_base_q} + {{(FRAME_W - IDX_W){1'b0}}, grant_idx})
				: '0;
			wake_evictor <= free_next <= low_mark_q;
			freed        <= is_rel ? pick.rel_cnt : '0;
		end
	end

endmodule

// ===== hdl/pfa_table.sv =====
// pfa_table: frame table flops (used bits, owner, segment, page) and associative match
// depends on pfa_pkg
`timescale 1ns / 1ps

module pfa_table import pfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PID_W-1:0]  lookup_pid,
	input  logic [PAGE_W-1:0] lookup_page,
	input  table_upd_t        upd,
	output table_match_t      match
);

	frame_vec_t        used_q;
	logic [PID_W-1:0]  owner_q [FRAMES];
	logic [SEG_W-1:0]  seg_q   [FRAMES];
	logic [PAGE_W-1:0] page_q  [FRAMES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= (used_q & ~(upd.release_en ? upd.rel_vec : '0))
				| (upd.claim ? (frame_vec_t'(1) << upd.claim_idx) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (upd.claim) begin
			owner_q[upd.claim_idx] <= upd.pid;
			seg_q[upd.claim_idx]   <= upd.seg;
			page_q[upd.claim_idx]  <= upd.page;
		end
	end

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			match.free_vec[i]  = !used_q[i];
			match.share_vec[i] = used_q[i] && (page_q[i] == lookup_page)
				&& (seg_q[i] == SHARED_SEG);
			match.rel_vec[i]   = used_q[i] && (owner_q[i] == lookup_pid)
				&& (seg_q[i] != SHARED_SEG);
		end
	end

endmodule

// ===== hdl/pfa_pick.sv =====
// pfa_pick: lowest-index pick of free and shared entries, count of released entries
// depends on pfa_pkg
`timescale 1ns / 1ps

module pfa_pick import pfa_pkg::*; (
	input  table_match_t match,
	output pick_t        pick
);

	function automatic logic [IDX_W-1:0] lowest(input frame_vec_t v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	always_comb begin
		pick.free_any  = |match.free_vec;
		pick.free_idx  = lowest(match.free_vec);
		pick.share_any = |match.share_vec;
		pick.share_idx = lowest(match.share_vec);
		pick.rel_cnt   = CNT_W'($countones(match.rel_vec));
	end

endmodule

// ===== hdl/pfa_checker.sv =====
// pfa_checker: port-level checks of the page frame allocator, bound to the top level
// depends on pfa_pkg and page_frame_allocator_shared
`timescale 1ns / 1ps

module pfa_checker import pfa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [FRAME_W-1:0] frame,
	input logic               granted,
	input logic               shared_hit,
	input logic [CNT_W-1:0]   freed
);

	// every accepted transaction is followed by its result on done
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted transaction without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a transaction");

	a_hit_granted: assert property (@(posedge clk) disable iff (!arst_n)
		(done && shared_hit) |-> granted)
		else $error("shared hit without grant");

	a_grant_no_freed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && granted) |-> (freed == '0))
		else $error("grant reports freed entries");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |-> (frame == '0))
		else $error("frame nonzero without grant");

endmodule

bind page_frame_allocator_shared pfa_checker u_pfa_checker (.*);
